/* rtl/tiled_font_glyph_blitter_core_macros.svh */
// ---------------------------------------------------------------------------
// tiled font glyph blitter assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ---------------------------------------------------------------------------
`ifndef TILED_FONT_GLYPH_BLITTER_CORE_MACROS_SVH
`define TILED_FONT_GLYPH_BLITTER_CORE_MACROS_SVH

// condition must hold at every edge out of reset
`define TFGB_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TFGB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/tfgb_pkg.sv */
// ---------------------------------------------------------------------------
// tfgb_pkg
// types and constants shared by the glyph blitter front, queue and back end
// ---------------------------------------------------------------------------
`default_nettype none

package tfgb_pkg;

  localparam int CANVAS_WIDTH  = 256;
  localparam int CANVAS_HEIGHT = 192;

  // pixels per bitmap word, in scan order
  localparam int NUM_PIX   = 16;
  localparam int PIX_IDX_W = $clog2(NUM_PIX);

  // front-to-back job queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] KEEP_ALL  = 8'hff;
  localparam logic [7:0] KEEP_HIGH = 8'hf0;
  localparam logic [7:0] KEEP_LOW  = 8'h0f;

  typedef struct packed {
    logic [7:0]         word_index;
    logic [31:0]        packed_row;
    logic               glyph_is_wide;
    logic [7:0]         glyph_advance;
    logic [7:0]         glyph_top;
    logic [7:0]         glyph_height;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [3:0]         ink_color;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [14:0] byte_address;
    logic [7:0]  keep_mask;
    logic [7:0]  set_bits;
    logic [7:0]  advance_out;
    logic        clipped;
    logic        last_result;
  } out_item_t;

  // classified word: pixel codes in scan order plus the pixels to draw
  typedef struct packed {
    logic [2*NUM_PIX-1:0] codes;
    logic [NUM_PIX-1:0]   draw_mask;
    logic                 wide;
    logic [7:0]           px0;
    logic [7:0]           py0;
    logic [3:0]           ink;
    logic [7:0]           advance;
    logic                 clipped;
  } job_t;

endpackage

`default_nettype wire

/* rtl/tfgb_front.sv */
// ---------------------------------------------------------------------------
// tfgb_front
// classifies one bitmap word: clipping, row range and per-pixel draw mask
// ---------------------------------------------------------------------------
`default_nettype none

module tfgb_front
  import tfgb_pkg::*;
(
  input  var in_item_t item,
  output job_t         job
);

  logic [17:0] x_ext, x_end, y_ext, y_end;
  logic [8:0]  row0, row1;
  logic        row0_ok, row1_ok, clip, draw;
  logic [1:0]  code;

  always_comb begin
    x_ext = {{2{item.dest_x[15]}}, item.dest_x};
    x_end = x_ext + {10'd0, item.glyph_advance};
    y_ext = {{2{item.dest_y[15]}}, item.dest_y} + {10'd0, item.glyph_top};
    y_end = y_ext + {10'd0, item.glyph_height};

    // negative start shows in the sign bit; otherwise the ends stay positive
    clip = x_ext[17] || (x_end > 18'(CANVAS_WIDTH)) ||
           y_ext[17] || (y_end > 18'(CANVAS_HEIGHT));
    draw = (item.glyph_advance != 8'd0) && !clip;

    row0    = item.glyph_is_wide ? {1'b0, item.word_index} : {item.word_index, 1'b0};
    row1    = {item.word_index, 1'b1};
    row0_ok = row0 < {1'b0, item.glyph_height};
    row1_ok = row1 < {1'b0, item.glyph_height};

    job.wide    = item.glyph_is_wide;
    job.px0     = x_ext[7:0];
    job.py0     = y_ext[7:0] + row0[7:0];
    job.ink     = item.ink_color;
    job.advance = item.glyph_advance;
    job.clipped = (item.glyph_advance != 8'd0) && clip;

    // wide and narrow share one bit layout: pixel p sits at 4*(p%8) + 2*(p/8)
    for (int p = 0; p < NUM_PIX; p++) begin
      code = item.packed_row[4*(p%8) + 2*(p/8) +: 2];
      job.codes[2*p +: 2] = code;
      job.draw_mask[p]    = draw && (code != 2'd0) &&
                            ((p < 8 || item.glyph_is_wide) ? row0_ok : row1_ok);
    end
  end

endmodule

`default_nettype wire

/* rtl/tfgb_fifo.sv */
// ---------------------------------------------------------------------------
// tfgb_fifo
// short job queue between the classifier and the write sequencer
// ---------------------------------------------------------------------------
`default_nettype none

module tfgb_fifo
  import tfgb_pkg::*;
(
  input  var logic clk,
  input  var logic rst_n,
  input  var logic push,
  input  var job_t push_job,
  output var logic full,
  input  var logic pop,
  output var logic valid,
  output var job_t head
);

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  always_comb begin
    full       = cnt_r == Q_CNT_W'(Q_DEPTH);
    valid      = cnt_r != '0;
    head       = slot_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && valid;
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* rtl/tfgb_back.sv */
// ---------------------------------------------------------------------------
// tfgb_back
// walks the head draw mask, one byte write per unstalled cycle, then status
// ---------------------------------------------------------------------------
`default_nettype none

`include "tiled_font_glyph_blitter_core_macros.svh"

module tfgb_back
  import tfgb_pkg::*;
(
  input  var logic      clk,
  input  var logic      rst_n,
  input  var logic      q_valid,
  input  var job_t      q_head,
  output var logic      q_pop,
  output var logic      out_empty,
  input  var logic      out_pop,
  output var out_item_t out_item
);

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;
  logic                 started_r, started_nxt;
  logic [NUM_PIX-1:0]   rem_r, rem_nxt;
  logic [NUM_PIX-1:0]   pending;
  logic [PIX_IDX_W-1:0] sel;
  logic                 has_pix, step;
  logic [1:0]           code;
  logic [8:0]           px;
  logic [7:0]           py;
  logic [4:0]           val;
  logic [15:0]          addr;

  always_comb begin
    step    = !out_valid_r || out_pop;
    pending = started_r ? rem_r : q_head.draw_mask;
    has_pix = |pending;

    // lowest pending pixel first
    sel = '0;
    for (int p = NUM_PIX - 1; p >= 0; p--) begin
      if (pending[p]) begin
        sel = PIX_IDX_W'(p);
      end
    end

    code = q_head.codes[{sel, 1'b0} +: 2];
    px   = {1'b0, q_head.px0} +
           (q_head.wide ? {5'd0, sel} : {6'd0, sel[2:0]});
    py   = q_head.py0 + {7'd0, !q_head.wide && sel[3]};

    // 64x64 tiles of 8x8 blocks, four bytes per block row
    addr = {1'b0, py[7:6], 13'd0} + {5'd0, py[5:3], 8'd0} + {11'd0, py[2:0], 2'd0} +
           {2'd0, px[8:6], 11'd0} + {8'd0, px[5:3], 5'd0} + {14'd0, px[2:1]};

    // ink plus the or-in bit; may carry into bit 4
    val = (code[0] ? {1'b0, q_head.ink} : 5'd0) + {4'd0, code[1]};

    out_nxt              = '0;
    out_nxt.advance_out  = q_head.advance;
    if (has_pix) begin
      out_nxt.write_valid  = 1'b1;
      out_nxt.byte_address = addr[14:0];
      out_nxt.keep_mask    = code[0] ? (px[0] ? KEEP_LOW : KEEP_HIGH) : KEEP_ALL;
      out_nxt.set_bits     = px[0] ? {val[3:0], 4'd0} : {3'd0, val};
    end else begin
      out_nxt.clipped     = q_head.clipped;
      out_nxt.last_result = 1'b1;
    end

    q_pop         = step && q_valid && !has_pix;
    out_valid_nxt = step ? q_valid : out_valid_r;
    started_nxt   = started_r;
    rem_nxt       = rem_r;
    if (step && q_valid) begin
      started_nxt = has_pix;
      rem_nxt     = pending & ~(NUM_PIX'(1) << sel);
    end

    out_empty = !out_valid_r;
    out_item  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      rem_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && q_valid) begin
      out_r <= out_nxt;
    end
  end

  `TFGB_ASSERT_IMPLY(a_started_has_job, started_r, q_valid, "walk in progress without a job")
  `TFGB_ASSERT_ALWAYS(a_rem_in_mask, (rem_r & ~q_head.draw_mask) == '0 || !started_r, "remaining pixels outside draw mask")
  `TFGB_ASSERT_IMPLY(a_pop_on_status, q_pop, !out_nxt.write_valid && out_nxt.last_result, "job retired on a byte write")
  `TFGB_ASSERT_IMPLY(a_keep_form, out_valid_r && out_r.write_valid, out_r.keep_mask == KEEP_ALL || out_r.keep_mask == KEEP_HIGH || out_r.keep_mask == KEEP_LOW, "malformed keep mask")

endmodule

`default_nettype wire

/* rtl/tiled_font_glyph_blitter_core.sv */
// ---------------------------------------------------------------------------
// tiled_font_glyph_blitter_core
// glyph word to masked byte writes for a 64x64-tiled 4bpp canvas
// ---------------------------------------------------------------------------
// Each item is one 32-bit bitmap word of a glyph with its geometry, screen
// position and ink. The block returns one masked byte write per nonzero
// pixel code that lands in a valid row (the caller does new = (old & keep) |
// set), followed by one status item with last_result set that carries the
// advance and the clip flag. A zero advance or a glyph outside the canvas
// gives the status item only. An item holds the write sequencer until its
// byte writes and status item (1 to 17 results) have gone out through the
// single result port, one item per cycle while the output register is empty
// or popped. The classifier takes a new item every cycle while the two-entry
// job queue has room, so later words are classified while the current one is
// still being written out. Results wait in an output register until popped.
// ---------------------------------------------------------------------------
`default_nettype none

module tiled_font_glyph_blitter_core
  import tfgb_pkg::*;
(
  input  var logic      clk,
  input  var logic      rst_n,
  // input queue side
  input  var logic      in_push,
  output var logic      in_full,
  input  var in_item_t  in_item,
  // result queue side
  output var logic      out_empty,
  input  var logic      out_pop,
  output var out_item_t out_item
);

  // classified job for the word on the input ports
  job_t front_job;
  // head of the job queue
  job_t head_job;
  logic head_valid;
  logic head_pop;

  // front: clip test, row range and draw mask, purely combinational
  tfgb_front u_front (
    .item (in_item),
    .job  (front_job)
  );

  // decouples classification from the byte-write walk
  tfgb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_job (front_job),
    .full     (in_full),
    .pop      (head_pop),
    .valid    (head_valid),
    .head     (head_job)
  );

  // back: one result item per cycle into the output register while it is empty or popped
  tfgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_head    (head_job),
    .q_pop     (head_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
